[rtl/core/fixed_partition_fit_allocator_core_defines.svh]
// Assertion macros shared by the fit allocator checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define FPFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fit allocator assertion failed");

// Next-cycle implication.
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fit allocator assertion failed");

`endif

[rtl/core/fpfa_pkg.sv]
// Package for the fixed partition fit allocator.
// Sizes, command and register codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int MAX_PARTS = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS  = 4;
    localparam int CNT_BITS  = 5;
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_PART_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } fpfa_state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic step;
        logic commit;
    } fpfa_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } fpfa_stat_t;

endpackage

[rtl/core/fpfa_regs.sv]
// Configuration registers of the fit allocator behind the APB-style port.
// Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpfa_pkg::ADDR_BITS-1:0] paddr,
    input  logic [fpfa_pkg::DATA_BITS-1:0] pwdata,
    output logic [fpfa_pkg::DATA_BITS-1:0] prdata,
    output logic [1:0]                     fit_mode,
    output logic [fpfa_pkg::CNT_BITS-1:0]  partition_count
);

    logic [1:0]                    fit_mode_reg;
    logic [fpfa_pkg::CNT_BITS-1:0] part_count_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= fpfa_pkg::FIT_FIRST;
            part_count_reg <= '0;
        end
        else if (wr_en)
        begin
            if (reg_sel == fpfa_pkg::REG_FIT_MODE)
            begin
                fit_mode_reg <= pwdata[1:0];
            end
            else
            begin
                part_count_reg <= pwdata[fpfa_pkg::CNT_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            fpfa_pkg::REG_FIT_MODE:
                prdata = {{(fpfa_pkg::DATA_BITS-2){1'b0}}, fit_mode_reg};
            fpfa_pkg::REG_PART_COUNT:
                prdata = {{(fpfa_pkg::DATA_BITS-fpfa_pkg::CNT_BITS){1'b0}}, part_count_reg};
            default:
                prdata = '0;
        endcase
    end

    assign fit_mode        = fit_mode_reg;
    assign partition_count = part_count_reg;

endmodule

[rtl/core/fpfa_ctrl.sv]
// Controller state machine of the fit allocator: accept, scan, commit.
// Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 cmd,
    input  fpfa_pkg::fpfa_stat_t stat,
    output logic                 in_ready,
    output fpfa_pkg::fpfa_ctrl_t ctrl
);

    fpfa_pkg::fpfa_state_t state_reg;
    fpfa_pkg::fpfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd == fpfa_pkg::CMD_LOAD)
                    begin
                        ctrl.load_we = 1'b1;
                    end
                    else
                    begin
                        ctrl.start = 1'b1;
                        state_next = fpfa_pkg::ST_SCAN;
                    end
                end
            end
            fpfa_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = fpfa_pkg::ST_COMMIT;
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            fpfa_pkg::ST_COMMIT:
            begin
                // hold here until the output register can take the result
                ctrl.commit = 1'b1;
                if (stat.out_free)
                begin
                    state_next = fpfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/fpfa_dp.sv]
// Datapath of the fit allocator: partition space store, scan comparator,
// pick tracking and the result register. Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fpfa_pkg::fpfa_ctrl_t           ctrl,
    input  logic [fpfa_pkg::IDX_BITS-1:0]  part_index,
    input  logic [fpfa_pkg::SIZE_BITS-1:0] amount,
    input  logic [1:0]                     fit_mode,
    input  logic [fpfa_pkg::CNT_BITS-1:0]  partition_count,
    input  logic                           out_ready,
    output fpfa_pkg::fpfa_stat_t           stat,
    output logic                           out_valid,
    output logic                           granted,
    output logic [fpfa_pkg::IDX_BITS-1:0]  chosen_part,
    output logic [fpfa_pkg::SIZE_BITS-1:0] space_before
);

    logic [fpfa_pkg::SIZE_BITS-1:0] mem_reg [fpfa_pkg::MAX_PARTS];

    logic [fpfa_pkg::SIZE_BITS-1:0] req_reg;
    logic [fpfa_pkg::CNT_BITS-1:0]  scan_idx_reg;
    logic                           found_reg;
    logic [fpfa_pkg::IDX_BITS-1:0]  pick_reg;
    logic [fpfa_pkg::SIZE_BITS-1:0] best_reg;
    logic                           out_valid_reg;
    logic                           granted_reg;
    logic [fpfa_pkg::IDX_BITS-1:0]  chosen_reg;
    logic [fpfa_pkg::SIZE_BITS-1:0] space_reg;

    logic [fpfa_pkg::CNT_BITS-1:0]  limit;
    logic [fpfa_pkg::SIZE_BITS-1:0] entry;
    logic                           fits;
    logic                           take;
    logic                           first_mode;
    logic                           out_free;
    logic                           load_ok;

    assign limit = (partition_count > fpfa_pkg::CNT_BITS'(fpfa_pkg::MAX_PARTS))
                 ? fpfa_pkg::CNT_BITS'(fpfa_pkg::MAX_PARTS) : partition_count;

    assign entry      = mem_reg[scan_idx_reg[fpfa_pkg::IDX_BITS-1:0]];
    assign fits       = entry >= req_reg;
    assign first_mode = (fit_mode != fpfa_pkg::FIT_BEST) && (fit_mode != fpfa_pkg::FIT_WORST);
    assign take       = fits && (!found_reg
                      || ((fit_mode == fpfa_pkg::FIT_BEST) && (entry < best_reg))
                      || ((fit_mode == fpfa_pkg::FIT_WORST) && (entry > best_reg)));

    assign out_free = !out_valid_reg || out_ready;
    assign load_ok  = {1'b0, part_index} < fpfa_pkg::CNT_BITS'(fpfa_pkg::MAX_PARTS);

    assign stat.scan_done = (scan_idx_reg >= limit) || (found_reg && first_mode);
    assign stat.out_free  = out_free;

    // partition store, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.load_we && load_ok)
        begin
            mem_reg[part_index] <= amount;
        end
        else if (ctrl.commit && found_reg)
        begin
            mem_reg[pick_reg] <= best_reg - req_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            req_reg <= amount;
        end
        if (ctrl.step && take)
        begin
            pick_reg <= scan_idx_reg[fpfa_pkg::IDX_BITS-1:0];
            best_reg <= entry;
        end
        if (ctrl.commit && out_free)
        begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? pick_reg : '0;
            space_reg   <= found_reg ? best_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (ctrl.step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctrl.commit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign chosen_part  = chosen_reg;
    assign space_before = space_reg;

endmodule

[rtl/core/fixed_partition_fit_allocator_core.sv]
// Top level of the fixed partition fit allocator.
// Instantiates fpfa_regs, fpfa_ctrl and fpfa_dp; depends on fpfa_pkg.
// A load gives no result. An allocate holds off further input until it
// commits: it scans the partitions below partition_count (at most sixteen)
// one at a time through the single read port and comparator of the store,
// closes the scan, then writes back the reduced space and loads the result
// register, waiting there while that register holds an unread result. First
// fit stops the scan at the first partition that fits. The result register
// takes the result while the input side goes on with loads. The partition
// store has no reset and needs no clearing pass; allocate only over partitions
// that have been loaded.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpfa_pkg::ADDR_BITS-1:0] paddr,
    input  logic [fpfa_pkg::DATA_BITS-1:0] pwdata,
    output logic [fpfa_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [fpfa_pkg::IDX_BITS-1:0]  part_index,
    input  logic [fpfa_pkg::SIZE_BITS-1:0] amount,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           granted,
    output logic [fpfa_pkg::IDX_BITS-1:0]  chosen_part,
    output logic [fpfa_pkg::SIZE_BITS-1:0] space_before
);

    logic [1:0]                    fit_mode;
    logic [fpfa_pkg::CNT_BITS-1:0] partition_count;
    fpfa_pkg::fpfa_ctrl_t          ctrl;
    fpfa_pkg::fpfa_stat_t          stat;

    assign pready = 1'b1;

    fpfa_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .fit_mode        (fit_mode),
        .partition_count (partition_count)
    );

    fpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .stat     (stat),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    fpfa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .part_index      (part_index),
        .amount          (amount),
        .fit_mode        (fit_mode),
        .partition_count (partition_count),
        .out_ready       (out_ready),
        .stat            (stat),
        .out_valid       (out_valid),
        .granted         (granted),
        .chosen_part     (chosen_part),
        .space_before    (space_before)
    );

endmodule

[rtl/core/fpfa_checker.sv]
// Port-level checker for the fit allocator, bound to the top level.
// Depends on fpfa_pkg and fixed_partition_fit_allocator_core_defines.svh.
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_core_defines.svh"

module fpfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           cmd,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           granted,
    input logic [fpfa_pkg::IDX_BITS-1:0]  chosen_part,
    input logic [fpfa_pkg::SIZE_BITS-1:0] space_before
);

    `FPFA_ASSERT_NOW(a_refused_zero, out_valid && !granted,
        (chosen_part == '0) && (space_before == '0))
    `FPFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(granted) && $stable(chosen_part) && $stable(space_before))
    `FPFA_ASSERT_NEXT(a_alloc_busy, in_valid && in_ready && (cmd == fpfa_pkg::CMD_ALLOC),
        !in_ready)
    `FPFA_ASSERT_NEXT(a_load_no_result,
        in_valid && in_ready && (cmd == fpfa_pkg::CMD_LOAD) && !out_valid, !out_valid)

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (.*);

[sim/fixed_partition_fit_allocator_core_tb.sv]
// Self-checking bench for the fixed partition fit allocator core.
// Drives load and allocate commands, writes fit mode and partition count over APB,
// predicts each grant in-line; depends on fpfa_pkg and the core RTL.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_core_tb;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int BATCH_ITEMS   = 100;
    localparam int NUM_BATCHES   = 9;
    localparam int FULL_SIZE     = (1 << fpfa_pkg::SIZE_BITS) - 1;

    localparam logic [1:0] FIT_SPARE = 2'd3;

    typedef struct packed {
        logic                           op;
        logic [fpfa_pkg::IDX_BITS-1:0]  index;
        logic [fpfa_pkg::SIZE_BITS-1:0] size;
    } part_cmd_t;

    typedef struct packed {
        logic                           granted;
        logic [fpfa_pkg::IDX_BITS-1:0]  chosen_part;
        logic [fpfa_pkg::SIZE_BITS-1:0] space_before;
    } grant_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [fpfa_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [fpfa_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [fpfa_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           cmd = fpfa_pkg::CMD_LOAD;
    logic [fpfa_pkg::IDX_BITS-1:0]  part_index = '0;
    logic [fpfa_pkg::SIZE_BITS-1:0] amount = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           granted;
    logic [fpfa_pkg::IDX_BITS-1:0]  chosen_part;
    logic [fpfa_pkg::SIZE_BITS-1:0] space_before;

    fixed_partition_fit_allocator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .part_index   (part_index),
        .amount       (amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .chosen_part  (chosen_part),
        .space_before (space_before)
    );

    always #6 clk = ~clk;

    part_cmd_t                      pending_cmds[$];
    grant_t                         awaited_grants[$];
    logic [fpfa_pkg::SIZE_BITS-1:0] free_space[fpfa_pkg::MAX_PARTS];
    logic [1:0]                     fit_mode_cfg = fpfa_pkg::FIT_FIRST;
    logic [fpfa_pkg::CNT_BITS-1:0]  part_count_cfg = '0;
    part_cmd_t                      cur_cmd;
    bit                             in_flight = 1'b0;
    bit                             send_hold = 1'b0;
    int                             send_idle_pct = 15;
    int                             recv_idle_pct = 74;
    int                             accepted_cmds = 0;
    int                             mismatches = 0;
    int                             stall_cycles = 0;

    function automatic grant_t place_request(input logic [fpfa_pkg::SIZE_BITS-1:0] req);
        grant_t r;
        int     limit;
        int     pick;
        bit     found;
        bit     done;
        r = '0;
        pick = 0;
        found = 1'b0;
        done = 1'b0;
        limit = (part_count_cfg > fpfa_pkg::CNT_BITS'(fpfa_pkg::MAX_PARTS))
              ? fpfa_pkg::MAX_PARTS : int'(part_count_cfg);
        for (int j = 0; j < limit; j++)
        begin
            if (!done && free_space[j] >= req)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick = j;
                    if (fit_mode_cfg != fpfa_pkg::FIT_BEST
                            && fit_mode_cfg != fpfa_pkg::FIT_WORST)
                        done = 1'b1;
                end
                else if (fit_mode_cfg == fpfa_pkg::FIT_BEST
                        && free_space[j] < free_space[pick])
                    pick = j;
                else if (fit_mode_cfg == fpfa_pkg::FIT_WORST
                        && free_space[j] > free_space[pick])
                    pick = j;
            end
        end
        if (found)
        begin
            r.granted = 1'b1;
            r.chosen_part = pick[fpfa_pkg::IDX_BITS-1:0];
            r.space_before = free_space[pick];
            free_space[pick] = free_space[pick] - req;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_flight = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_cmds++;
                if (cur_cmd.op == fpfa_pkg::CMD_LOAD)
                    free_space[cur_cmd.index] = cur_cmd.size;
                else
                    awaited_grants.push_back(place_request(cur_cmd.size));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() > 0 && !send_hold
                        && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    cmd <= cur_cmd.op;
                    part_index <= cur_cmd.index;
                    amount <= cur_cmd.size;
                    in_flight = 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    in_flight = 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        grant_t exp_grant;
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_grants.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: granted=%0d part=%0d space=%0d",
                             granted, chosen_part, space_before);
                mismatches++;
            end
            else
            begin
                exp_grant = awaited_grants.pop_front();
                if (granted !== exp_grant.granted || chosen_part !== exp_grant.chosen_part
                        || space_before !== exp_grant.space_before)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 exp_grant.granted, exp_grant.chosen_part,
                                 exp_grant.space_before, granted, chosen_part,
                                 space_before);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic reg_sel,
                             input logic [fpfa_pkg::DATA_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == fpfa_pkg::REG_FIT_MODE)
            fit_mode_cfg = value[1:0];
        else
            part_count_cfg = value[fpfa_pkg::CNT_BITS-1:0];
        @(negedge clk);
    endtask

    task automatic set_policy(input logic [1:0] mode, input int count);
        write_reg(fpfa_pkg::REG_FIT_MODE, fpfa_pkg::DATA_BITS'(mode));
        write_reg(fpfa_pkg::REG_PART_COUNT, fpfa_pkg::DATA_BITS'(count));
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() != 0 || in_flight || awaited_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_cmd(input logic op, input int idx, input int size);
        part_cmd_t c;
        c.op = op;
        c.index = idx[fpfa_pkg::IDX_BITS-1:0];
        c.size = size[fpfa_pkg::SIZE_BITS-1:0];
        pending_cmds.push_back(c);
    endtask

    function automatic part_cmd_t random_cmd();
        part_cmd_t c;
        int        pick;
        c.index = fpfa_pkg::IDX_BITS'($urandom_range(fpfa_pkg::MAX_PARTS - 1));
        pick = int'($urandom_range(7));
        if ($urandom_range(99) < 30)
        begin
            c.op = fpfa_pkg::CMD_LOAD;
            if (pick < 2)
                c.size = fpfa_pkg::SIZE_BITS'($urandom);
            else if (pick == 2)
                c.size = {fpfa_pkg::SIZE_BITS{1'b1}}
                       - fpfa_pkg::SIZE_BITS'($urandom_range(15));
            else
                c.size = fpfa_pkg::SIZE_BITS'($urandom_range(4095));
        end
        else
        begin
            c.op = fpfa_pkg::CMD_ALLOC;
            if (pick == 0)
                c.size = '0;
            else if (pick == 1)
                c.size = fpfa_pkg::SIZE_BITS'($urandom);
            else
                c.size = fpfa_pkg::SIZE_BITS'($urandom_range(2047));
        end
        return c;
    endfunction

    logic [1:0] batch_mode[NUM_BATCHES] = '{fpfa_pkg::FIT_FIRST, fpfa_pkg::FIT_BEST,
                                            fpfa_pkg::FIT_WORST, fpfa_pkg::FIT_FIRST,
                                            fpfa_pkg::FIT_BEST, fpfa_pkg::FIT_WORST,
                                            FIT_SPARE, fpfa_pkg::FIT_BEST,
                                            fpfa_pkg::FIT_WORST};
    int         batch_count[NUM_BATCHES] = '{16, 16, 16, 4, 1, 9, 16, 31, 12};

    initial
    begin
        int base;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_policy(fpfa_pkg::FIT_FIRST, 0);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, 5);
        for (int i = 0; i < fpfa_pkg::MAX_PARTS; i++)
            queue_cmd(fpfa_pkg::CMD_LOAD, i, 1000 + 37 * i);
        queue_cmd(fpfa_pkg::CMD_LOAD, 0, 100);
        queue_cmd(fpfa_pkg::CMD_LOAD, 1, 50);
        queue_cmd(fpfa_pkg::CMD_LOAD, 2, FULL_SIZE);
        queue_cmd(fpfa_pkg::CMD_LOAD, 3, 50);
        queue_cmd(fpfa_pkg::CMD_LOAD, 4, 0);
        queue_cmd(fpfa_pkg::CMD_LOAD, 15, FULL_SIZE);
        wait_drained();

        set_policy(fpfa_pkg::FIT_BEST, fpfa_pkg::MAX_PARTS);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 9, 40);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, 0);
        wait_drained();

        set_policy(fpfa_pkg::FIT_WORST, fpfa_pkg::MAX_PARTS);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, FULL_SIZE);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, FULL_SIZE);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, FULL_SIZE);
        wait_drained();

        set_policy(FIT_SPARE, 31);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 15, 0);
        wait_drained();

        set_policy(fpfa_pkg::FIT_FIRST, 1);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, 101);
        queue_cmd(fpfa_pkg::CMD_ALLOC, 0, 100);
        wait_drained();

        for (int b = 0; b < NUM_BATCHES; b++)
        begin
            if (b < 3)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 74;
            end
            else if (b < 6)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_policy(batch_mode[b], batch_count[b]);
            base = accepted_cmds;
            for (int i = 0; i < BATCH_ITEMS; i++)
                pending_cmds.push_back(random_cmd());
            if (b == 4)
            begin
                do
                begin
                    @(negedge clk);
                end
                while (accepted_cmds < base + BATCH_ITEMS / 2);
                send_hold = 1'b1;
                do
                begin
                    @(negedge clk);
                end
                while (in_flight || awaited_grants.size() != 0);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        if (mismatches == 0 && awaited_grants.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
